[hw/rtl/tpsd_pkg.sv]
// Package for the transport-stream PID scrambling detector.
// Holds the beat layouts, table entry type, control types and constants.
// No dependencies; every other file in hw/rtl but tpsd_ram imports it.
package tpsd_pkg;

   // Default table depth, one entry per PID
   localparam int PID_COUNT_DEF = 8192;

   localparam int PID_W       = 13;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int THR_W       = 4;

   // Register map
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_THRESHOLD = 2'd0;
   localparam logic [THR_W-1:0]      THRESHOLD_RESET    = 4'd3;

   // Item opcodes (travel on req_tuser)
   localparam logic OP_ANALYSE = 1'b0;
   localparam logic OP_QUERY   = 1'b1;

   // PID states
   localparam logic [1:0] PST_NOT_SET   = 2'd0;
   localparam logic [1:0] PST_CLEAR     = 2'd1;
   localparam logic [1:0] PST_ENCRYPTED = 2'd2;

   // Packet constants
   localparam logic [7:0]  TS_SYNC_BYTE   = 8'h47;
   localparam logic [23:0] PES_START_CODE = 24'h000001;
   localparam logic [7:0]  PES_MAX_OFFSET = 8'd181;
   localparam logic [3:0]  COUNT_MAX      = 4'hf;

   // Stream ids whose PES header has no scrambling bits
   localparam logic [7:0] SID_PROG_MAP    = 8'hbc;
   localparam logic [7:0] SID_PADDING     = 8'hbe;
   localparam logic [7:0] SID_PRIVATE_2   = 8'hbf;
   localparam logic [7:0] SID_ECM         = 8'hf0;
   localparam logic [7:0] SID_EMM         = 8'hf1;
   localparam logic [7:0] SID_DSMCC       = 8'hf2;
   localparam logic [7:0] SID_H222_TYPE_E = 8'hf8;
   localparam logic [7:0] SID_PROG_DIR    = 8'hff;

   // Request tdata layout, lowest field last
   typedef struct packed {
      logic [4:0]  pad;
      logic [7:0]  pes_flags;
      logic [7:0]  stream_id;
      logic [23:0] start_code;
      logic [7:0]  payload_offset;
      logic        unit_start;
      logic [1:0]  scrambling_control;
      logic        has_adaptation;
      logic        adaptation_only;
      logic        transport_error;
      logic [7:0]  sync_byte;
      logic [12:0] pid;
   } req_data_type;

   // Response tdata layout, lowest field last
   typedef struct packed {
      logic [3:0]  pad;
      logic [12:0] pid_out;
      logic [1:0]  current_state;
      logic [1:0]  old_state;
      logic        state_changed;
      logic        clear_ts_bits;
      logic        scrambled;
   } rsp_data_type;

   // One table entry
   typedef struct packed {
      logic [3:0] count;
      logic [1:0] state;
   } entry_type;

   // Controller states
   typedef enum logic [1:0] {
      CST_CLEAR,
      CST_IDLE,
      CST_READ,
      CST_EVAL
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic clear_en;
      logic read_en;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } sts_type;

   function automatic logic stream_has_scrambling(input logic [7:0] sid);
      return !(sid == SID_PROG_MAP || sid == SID_PADDING || sid == SID_PRIVATE_2 ||
               sid == SID_ECM || sid == SID_EMM || sid == SID_DSMCC ||
               sid == SID_H222_TYPE_E || sid == SID_PROG_DIR);
   endfunction

endpackage

[hw/rtl/ts_pid_scrambling_detector.sv]
// Transport-stream PID scrambling detector. Each request beat is one packet
// summary (analyse) or a PID query; each gives exactly one response beat.
// An item goes through accept, table read, and evaluate and write back on its
// way to a loaded response, set by the read-modify-write of the per-PID table
// RAM; a stalled response holds the block in its evaluate step, while one
// further request may be accepted behind a waiting response. After reset a
// clearing pass writes every table entry before the first request beat is
// taken; the threshold register is writable throughout.
// Depends on tpsd_pkg, tpsd_ctrl, tpsd_dpath and tpsd_ram.
module ts_pid_scrambling_detector
   import tpsd_pkg::*;
#(
   parameter int PID_COUNT = PID_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // pid[12:0], sync_byte[20:13], transport_error[21], adaptation_only[22],
   // has_adaptation[23], scrambling_control[25:24], unit_start[26],
   // payload_offset[34:27], start_code[58:35], stream_id[66:59],
   // pes_flags[74:67], zero[79:75]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // opcode[0]
   input  logic                   req_tuser,
   // Response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // scrambled[0], clear_ts_bits[1], state_changed[2], old_state[4:3],
   // current_state[6:5], pid_out[19:7], zero[23:20]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // Configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   cmd_type cmd;
   sts_type sts;

   logic [THR_W-1:0] threshold_ff, threshold_in;
   logic             csr_wr;

   // Threshold register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_wr && csr_paddr == CSR_ADDR_THRESHOLD) begin
         threshold_in = csr_pwdata[THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   assign csr_prdata = (csr_paddr == CSR_ADDR_THRESHOLD) ?
                       {{(CSR_DATA_W - THR_W){1'b0}}, threshold_ff} : '0;

   tpsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tpsd_dpath #(
      .PID_COUNT (PID_COUNT)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .threshold  (threshold_ff),
      .req_opcode (req_tuser),
      .req_data   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_tdata)
   );

endmodule

[hw/rtl/tpsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the per-PID table; depends on nothing.
module tpsd_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/tpsd_ctrl.sv]
// Controller FSM of the PID scrambling detector: clearing pass, accept,
// table read and evaluate/write-back. Depends on tpsd_pkg.
module tpsd_ctrl
   import tpsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CST_CLEAR: begin
            if (sts.clear_last) state_in = CST_IDLE;
         end
         CST_IDLE: begin
            if (req_tvalid) state_in = CST_READ;
         end
         CST_READ: begin
            state_in = CST_EVAL;
         end
         CST_EVAL: begin
            if (sts.out_free) state_in = CST_IDLE;
         end
         default: begin
            state_in = CST_CLEAR;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         CST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         CST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         CST_READ: begin
            cmd.read_en = 1'b1;
         end
         CST_EVAL: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[hw/rtl/tpsd_dpath.sv]
// Datapath of the PID scrambling detector: item register, clear counter,
// per-PID table RAM, decision logic and response register.
// Depends on tpsd_pkg and tpsd_ram.
module tpsd_dpath
   import tpsd_pkg::*;
#(
   parameter int PID_COUNT = PID_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic [THR_W-1:0]       threshold,
   input  logic                   req_opcode,
   input  logic [REQ_TDATA_W-1:0] req_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_data
);

   localparam int IDX_W = $clog2(PID_COUNT);

   // Captured item
   logic         op_ff, op_in;
   req_data_type item_ff, item_in;

   // Clearing sweep counter
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;

   // Response register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_ff, rsp_in;

   // Table access
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic [$bits(entry_type)-1:0] rd_word;
   entry_type        entry;
   logic [IDX_W-1:0] item_idx;
   logic             in_range;

   // Decision
   logic       bad_pkt;
   logic       pes_scr;
   logic [3:0] cnt_inc;
   logic       flip_ok;
   logic [1:0] target;
   logic       scr, clr, chg, write_ok;
   entry_type  new_entry;

   assign item_idx = item_ff.pid[IDX_W-1:0];
   assign in_range = {1'b0, item_ff.pid} < (PID_W + 1)'(PID_COUNT);
   assign entry    = entry_type'(rd_word);

   tpsd_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (PID_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.read_en),
      .rd_addr (item_idx),
      .rd_data (rd_word)
   );

   // PES header decision
   always_comb begin
      pes_scr = 1'b0;
      if (!item_ff.has_adaptation || item_ff.payload_offset <= PES_MAX_OFFSET) begin
         if (item_ff.start_code != PES_START_CODE) begin
            pes_scr = 1'b1;
         end else if (stream_has_scrambling(item_ff.stream_id)) begin
            pes_scr = item_ff.pes_flags[5:4] != 2'd0;
         end
      end
   end

   // Hysteresis step toward the target state
   assign cnt_inc = (entry.count != COUNT_MAX) ? entry.count + 4'd1 : entry.count;
   assign flip_ok = (entry.state == PST_NOT_SET) || (cnt_inc >= threshold);
   assign target  = (item_ff.scrambling_control != 2'd0 || pes_scr) ?
                    PST_ENCRYPTED : PST_CLEAR;
   assign bad_pkt = (item_ff.sync_byte != TS_SYNC_BYTE) || item_ff.transport_error;

   // Packet analysis and table update
   always_comb begin
      scr       = 1'b0;
      clr       = 1'b0;
      chg       = 1'b0;
      write_ok  = 1'b0;
      new_entry = entry;
      if (op_ff == OP_ANALYSE) begin
         if (bad_pkt) begin
            scr = 1'b0;
         end else if (item_ff.adaptation_only) begin
            clr = 1'b1;
         end else if (!in_range) begin
            scr = 1'b0;
         end else if (item_ff.scrambling_control != 2'd0 || item_ff.unit_start) begin
            write_ok = 1'b1;
            scr      = (item_ff.scrambling_control != 2'd0) || pes_scr;
            if (entry.state == target) begin
               new_entry.count = 4'd0;
            end else if (flip_ok) begin
               new_entry.state = target;
               new_entry.count = 4'd0;
               chg             = 1'b1;
            end else begin
               new_entry.count = cnt_inc;
            end
         end else begin
            // continuation packet without TS scrambling
            scr = entry.state != PST_CLEAR;
         end
      end
   end

   // Table write: clearing sweep or write-back
   always_comb begin
      wr_en    = cmd.clear_en || (cmd.commit && write_ok);
      wr_addr  = cmd.clear_en ? clr_cnt_ff : item_idx;
      wr_entry = cmd.clear_en ? entry_type'('0) : new_entry;
   end

   // Register next values
   always_comb begin
      op_in   = cmd.load ? req_opcode : op_ff;
      item_in = cmd.load ? req_data_type'(req_data) : item_ff;

      clr_cnt_in = cmd.clear_en ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

      rsp_in = rsp_ff;
      if (cmd.commit) begin
         rsp_in.pad           = '0;
         rsp_in.scrambled     = scr;
         rsp_in.clear_ts_bits = clr;
         rsp_in.state_changed = chg;
         rsp_in.old_state     = in_range ? entry.state : PST_NOT_SET;
         rsp_in.current_state = in_range ? new_entry.state : PST_NOT_SET;
         rsp_in.pid_out       = item_ff.pid;
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   // Status back to the controller
   assign sts.clear_last = clr_cnt_ff == IDX_W'(PID_COUNT - 1);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

[test/tpsd_scramble_checker.sv]
// Checker for the TS PID scrambling detector: tracks the threshold register,
// predicts every response beat from the request beats and compares them.
// Depends on tpsd_pkg.
`timescale 1ns / 100ps

module tpsd_scramble_checker
   import tpsd_pkg::*;
#(
   parameter int PID_COUNT = PID_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic [CSR_DATA_W-1:0]  csr_prdata,
   input  logic                   csr_pready,
   output int                     outstanding,
   output int                     mismatches
);

   // Shadow of the per-PID table and the threshold register
   logic [1:0]       pid_state [PID_COUNT];
   logic [3:0]       pid_count [PID_COUNT];
   logic [THR_W-1:0] flip_threshold;

   rsp_data_type expected_rsp_q [$];
   rsp_data_type got_rsp;
   rsp_data_type want_rsp;
   rsp_data_type next_rsp;

   initial begin
      outstanding = 0;
      mismatches  = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Stream ids whose PES header carries no scrambling bits
   function automatic logic sid_carries_scrambling(input logic [7:0] sid);
      case (sid)
         SID_PROG_MAP, SID_PADDING, SID_PRIVATE_2, SID_ECM,
         SID_EMM, SID_DSMCC, SID_H222_TYPE_E, SID_PROG_DIR: return 1'b0;
         default: return 1'b1;
      endcase
   endfunction

   // One disagreeing packet towards target; flips on first evidence or at threshold
   task automatic push_state(input int idx, input logic [1:0] target, output logic flipped);
      if (pid_count[idx] != COUNT_MAX)
         pid_count[idx]++;
      flipped = 1'b0;
      if (pid_state[idx] == PST_NOT_SET || pid_count[idx] >= flip_threshold) begin
         pid_state[idx] = target;
         pid_count[idx] = '0;
         flipped        = 1'b1;
      end
   endtask

   // Expected response for one request beat; updates the shadow table
   task automatic judge_packet(input logic op, input req_data_type d, output rsp_data_type r);
      logic       in_range;
      int         idx;
      logic [1:0] prior;
      logic       scr;
      logic       clr;
      logic       chg;
      logic       pes;
      in_range = d.pid < PID_COUNT;
      idx      = in_range ? int'(d.pid) : 0;
      prior    = in_range ? pid_state[idx] : PST_NOT_SET;
      scr = 1'b0;
      clr = 1'b0;
      chg = 1'b0;
      pes = 1'b0;
      if (op == OP_ANALYSE) begin
         if (d.sync_byte != TS_SYNC_BYTE || d.transport_error) begin
            // malformed: nothing judged, table untouched
         end else if (d.adaptation_only) begin
            clr = 1'b1;
         end else if (!in_range) begin
            // untracked pid
         end else if (d.scrambling_control != 2'b00) begin
            scr = 1'b1;
            if (pid_state[idx] == PST_ENCRYPTED)
               pid_count[idx] = '0;
            else
               push_state(idx, PST_ENCRYPTED, chg);
         end else if (!d.unit_start) begin
            // continuation: follows the known state, no table change
            scr = pid_state[idx] != PST_CLEAR;
         end else begin
            // PES start: header reachable unless adaptation pushes it past the end
            if (!d.has_adaptation || d.payload_offset <= PES_MAX_OFFSET) begin
               if (d.start_code != PES_START_CODE)
                  pes = 1'b1;
               else if (sid_carries_scrambling(d.stream_id))
                  pes = d.pes_flags[5:4] != 2'b00;
            end
            if ((pes && pid_state[idx] != PST_ENCRYPTED) ||
                (!pes && pid_state[idx] != PST_CLEAR))
               push_state(idx, pes ? PST_ENCRYPTED : PST_CLEAR, chg);
            else
               pid_count[idx] = '0;
            scr = pes;
         end
      end
      r               = '0;
      r.scrambled     = scr;
      r.clear_ts_bits = clr;
      r.state_changed = chg;
      r.old_state     = prior;
      r.current_state = in_range ? pid_state[idx] : PST_NOT_SET;
      r.pid_out       = d.pid;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PID_COUNT; i++) begin
            pid_state[i] = PST_NOT_SET;
            pid_count[i] = '0;
         end
         flip_threshold = THRESHOLD_RESET;
         expected_rsp_q.delete();
         outstanding = 0;
      end else begin
         // register writes and readback
         if (csr_psel && csr_penable && csr_pready && csr_paddr == CSR_ADDR_THRESHOLD) begin
            if (csr_pwrite)
               flip_threshold = csr_pwdata[THR_W-1:0];
            else if (csr_prdata != {{(CSR_DATA_W-THR_W){1'b0}}, flip_threshold})
               report_mismatch("threshold readback", csr_prdata,
                               {{(CSR_DATA_W-THR_W){1'b0}}, flip_threshold});
         end

         // response beat against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = rsp_data_type'(rsp_tdata);
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response beat with nothing expected", 32'(rsp_tdata), '0);
            end else begin
               want_rsp = expected_rsp_q.pop_front();
               if (got_rsp.scrambled != want_rsp.scrambled)
                  report_mismatch("scrambled", 32'(got_rsp.scrambled),
                                  32'(want_rsp.scrambled));
               if (got_rsp.clear_ts_bits != want_rsp.clear_ts_bits)
                  report_mismatch("clear_ts_bits", 32'(got_rsp.clear_ts_bits),
                                  32'(want_rsp.clear_ts_bits));
               if (got_rsp.state_changed != want_rsp.state_changed)
                  report_mismatch("state_changed", 32'(got_rsp.state_changed),
                                  32'(want_rsp.state_changed));
               if (got_rsp.old_state != want_rsp.old_state)
                  report_mismatch("old_state", 32'(got_rsp.old_state),
                                  32'(want_rsp.old_state));
               if (got_rsp.current_state != want_rsp.current_state)
                  report_mismatch("current_state", 32'(got_rsp.current_state),
                                  32'(want_rsp.current_state));
               if (got_rsp.pid_out != want_rsp.pid_out)
                  report_mismatch("pid_out", 32'(got_rsp.pid_out),
                                  32'(want_rsp.pid_out));
               if (got_rsp.pad != want_rsp.pad)
                  report_mismatch("tdata padding", 32'(got_rsp.pad), 32'(want_rsp.pad));
            end
         end

         // request beat: predict its response
         if (req_tvalid && req_tready) begin
            judge_packet(req_tuser, req_data_type'(req_tdata), next_rsp);
            expected_rsp_q.push_back(next_rsp);
         end

         outstanding = expected_rsp_q.size();
      end
   end

endmodule

[test/ts_pid_scrambling_detector_tb.sv]
// Testbench top for the TS PID scrambling detector: clock, reset, request and
// register stimulus, response back-pressure and the verdict.
// Depends on tpsd_pkg, ts_pid_scrambling_detector and tpsd_scramble_checker.
`timescale 1ns / 100ps

module ts_pid_scrambling_detector_tb;
   import tpsd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int END_SETTLE   = 20;
   localparam int PHASE_ITEMS  = 108;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int   outstanding;
   int   mismatches;
   int   cycles = 0;
   logic no_idle = 1'b0;
   int   rsp_stall;

   logic [12:0] pid_pool [6];
   logic [5:0]  pid_trend;
   logic [7:0]  plain_sids [8];

   ts_pid_scrambling_detector DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tpsd_scramble_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response back-pressure: a fresh random stall, possibly none, after every accepted beat
   initial begin
      rsp_tready = 1'b0;
      rsp_stall  = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            rsp_stall = no_idle ? 0 : $urandom_range(0, 9);
         @(negedge clock);
         if (rsp_stall > 0) begin
            rsp_tready = 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Well-formed packet on pid: clean header, valid start code, unscrambled
   function automatic req_data_type clean_packet(input logic [12:0] pid);
      req_data_type p;
      p            = '0;
      p.pid        = pid;
      p.sync_byte  = TS_SYNC_BYTE;
      p.start_code = PES_START_CODE;
      return p;
   endfunction

   // One request beat after a random gap; tvalid stays high on return
   task automatic send_item(input logic op, input req_data_type p);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = p;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off requests until every response beat is back
   task automatic drain();
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Register access: setup then access cycle
   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = CSR_ADDR_THRESHOLD;
      csr_pwdata  = wr ? value : '0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   initial begin
      req_data_type p;
      logic [12:0]  pid;
      logic         show;
      logic         op;
      int           slot;
      int           pick;
      int           thr_plan [6];

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_ANALYSE;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      pid_pool    = '{13'd0, 13'h1fff, 13'd5, 13'd100, 13'd4097, 13'd31};
      pid_trend   = 6'b101010;
      plain_sids  = '{SID_PROG_MAP, SID_PADDING, SID_PRIVATE_2, SID_ECM,
                      SID_EMM, SID_DSMCC, SID_H222_TYPE_E, SID_PROG_DIR};
      thr_plan    = '{1, 15, 0, 7, 2, 1};
      thr_plan[5] = $urandom_range(1, 15);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset value of the threshold
      csr_access(1'b0, '0);

      // Directed beats at the reset threshold
      send_item(OP_QUERY, clean_packet(13'd0));
      send_item(OP_QUERY, clean_packet(13'h1fff));
      p = clean_packet(13'd5);
      p.sync_byte = 8'h00;
      p.scrambling_control = 2'd3;
      send_item(OP_ANALYSE, p);
      p = clean_packet(13'd5);
      p.transport_error = 1'b1;
      p.scrambling_control = 2'd3;
      send_item(OP_ANALYSE, p);
      p = clean_packet(13'd5);
      p.adaptation_only = 1'b1;
      p.has_adaptation = 1'b1;
      p.scrambling_control = 2'd3;
      send_item(OP_ANALYSE, p);
      // first evidence sets encrypted, agreement keeps it
      p = clean_packet(13'd5);
      p.scrambling_control = 2'd1;
      send_item(OP_ANALYSE, p);
      p.scrambling_control = 2'd2;
      send_item(OP_ANALYSE, p);
      // continuation while encrypted
      send_item(OP_ANALYSE, clean_packet(13'd5));
      // three clear PES starts flip to clear
      p = clean_packet(13'd5);
      p.unit_start = 1'b1;
      p.stream_id = 8'he0;
      p.pes_flags = 8'h80;
      repeat (3) send_item(OP_ANALYSE, p);
      send_item(OP_ANALYSE, clean_packet(13'd5));
      // bad start code counts as scrambled
      p = clean_packet(13'd5);
      p.unit_start = 1'b1;
      p.start_code = 24'hffffff;
      p.stream_id = 8'he0;
      send_item(OP_ANALYSE, p);
      // stream ids with no scrambling bits
      for (int i = 0; i < 8; i++) begin
         p = clean_packet(13'd5);
         p.unit_start = 1'b1;
         p.stream_id = plain_sids[i];
         p.pes_flags = 8'hff;
         send_item(OP_ANALYSE, p);
      end
      // PES header out of reach, then just in reach
      p = clean_packet(13'h1fff);
      p.unit_start = 1'b1;
      p.has_adaptation = 1'b1;
      p.payload_offset = 8'd187;
      p.start_code = 24'h000000;
      p.stream_id = 8'he0;
      p.pes_flags = 8'h30;
      send_item(OP_ANALYSE, p);
      p.payload_offset = PES_MAX_OFFSET;
      p.start_code = PES_START_CODE;
      p.pes_flags = 8'h10;
      send_item(OP_ANALYSE, p);
      p = clean_packet(13'd0);
      p.scrambling_control = 2'd3;
      send_item(OP_ANALYSE, p);
      send_item(OP_QUERY, clean_packet(13'd5));

      // Random phases, one threshold each, written while idle
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         csr_access(1'b1, thr_plan[ph]);
         csr_access(1'b0, '0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 36 == 0)
               no_idle = ($urandom_range(0, 3) == 0);
            slot = $urandom_range(0, 7);
            pick = $urandom_range(0, 99);
            if (slot < 6) begin
               pid = pid_pool[slot];
               if ($urandom_range(0, 15) == 0)
                  pid_trend[slot] = ~pid_trend[slot];
               show = ($urandom_range(0, 4) != 0) ? pid_trend[slot] : ~pid_trend[slot];
            end else begin
               pid  = 13'($urandom);
               show = 1'($urandom_range(0, 1));
            end

            // start from fully random fields
            p.pad                = '0;
            p.pid                = pid;
            p.sync_byte          = 8'($urandom);
            p.transport_error    = 1'($urandom);
            p.adaptation_only    = 1'($urandom);
            p.has_adaptation     = 1'($urandom);
            p.scrambling_control = 2'($urandom);
            p.unit_start         = 1'($urandom);
            p.payload_offset     = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(182, 187))
                                                               : 8'($urandom_range(0, 187));
            p.start_code         = 24'($urandom);
            p.stream_id          = 8'($urandom);
            p.pes_flags          = 8'($urandom);

            if (pick < 8) begin
               op = OP_QUERY;
            end else if (pick < 20) begin
               // noise: broken headers, mostly with a good sync byte
               op = OP_ANALYSE;
               if (pick >= 12)
                  p.sync_byte = TS_SYNC_BYTE;
            end else begin
               // well-formed packet giving evidence for or against scrambling
               op = OP_ANALYSE;
               p.sync_byte       = TS_SYNC_BYTE;
               p.transport_error = 1'b0;
               p.adaptation_only = 1'b0;
               if ($urandom_range(0, 9) != 0)
                  p.start_code = PES_START_CODE;
               if (show) begin
                  if (pick % 2 == 0) begin
                     p.scrambling_control = 2'($urandom_range(1, 3));
                  end else begin
                     p.scrambling_control = 2'd0;
                     p.unit_start         = 1'b1;
                     p.pes_flags[5:4]     = 2'($urandom_range(1, 3));
                  end
               end else begin
                  p.scrambling_control = 2'd0;
                  p.unit_start         = (pick >= 30);
                  p.pes_flags[5:4]     = 2'd0;
                  if ($urandom_range(0, 3) == 0) begin
                     p.stream_id      = plain_sids[$urandom_range(0, 7)];
                     p.pes_flags[5:4] = 2'($urandom);
                  end
               end
            end
            send_item(op, p);
         end
      end

      // wind down
      no_idle = 1'b0;
      drain();
      repeat (END_SETTLE) @(negedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
